FILE: rtl/scap_pkg.sv
// ----------------------------------------------------------------------------
// scap_pkg
// Shared widths, register indexes and the item record that travels down the
// sphere contact projection pipeline.
// ----------------------------------------------------------------------------
package scap_pkg;

	localparam int FRAC_BITS = 16;
	localparam int WORD_BITS = 32;
	localparam int UW        = WORD_BITS - 1;        // unsigned field width
	localparam int DIFF_W    = WORD_BITS + 2;        // target - gap - center
	localparam int MAG_W     = WORD_BITS + 1;        // |d|
	localparam int SQ_W      = 2 * MAG_W;            // |d|^2
	localparam int SUM_W     = SQ_W + 2;             // sum of three squares
	localparam int ROOT_W    = SUM_W / 2;            // n
	localparam int QB        = ROOT_W;               // quotient bits and unit depth
	localparam int NUM_W     = 2 * QB;               // dividend width
	localparam int PRD_W     = UW + MAG_W;           // rho * |s|
	localparam int SH_W      = PRD_W - FRAC_BITS;
	localparam int GAIN_SH   = 2;                    // stiffness gain of four
	localparam int CFG_IDX_W = 3;

	localparam logic [UW-1:0] UMAX = '1;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_CENTER_X = 3'd0,
		CFG_CENTER_Y = 3'd1,
		CFG_CENTER_Z = 3'd2,
		CFG_RADIUS   = 3'd3,
		CFG_MARGIN   = 3'd4
	} cfg_idx_t;

	typedef struct packed {
		logic [2:0][WORD_BITS-1:0] u;
		logic [2:0][MAG_W-1:0]     ad;
		logic [2:0]                neg;
		logic [UW-1:0]             rho;
		logic [UW-1:0]             k;
		logic [ROOT_W-1:0]         n;
		logic                      gt;
		logic                      fire;
		logic                      ovf;
		logic                      zero;
		logic [QB-1:0]             alpha;
	} item_t;

endpackage

FILE: rtl/scap_delay.sv
// ----------------------------------------------------------------------------
// scap_delay
// Valid bits and item record kept in step with the sqrt and divider units.
// ----------------------------------------------------------------------------
module scap_delay import scap_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  en,
	input  logic  in_valid,
	input  item_t in_item,
	output logic  out_valid,
	output item_t out_item
);

	logic  valid_s [1:QB];
	item_t item_s  [1:QB];

	// one register per unit stage
	for (genvar g = 1; g <= QB; g++) begin : g_stage
		logic  v_prev;
		item_t i_prev;
		if (g == 1) begin : g_first
			assign v_prev = in_valid;
			assign i_prev = in_item;
		end else begin : g_next
			assign v_prev = valid_s[g-1];
			assign i_prev = item_s[g-1];
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				valid_s[g] <= 1'b0;
			else if (en)
				valid_s[g] <= v_prev;
		end
		always_ff @(posedge clk) begin
			if (en)
				item_s[g] <= i_prev;
		end
	end

	assign out_valid = valid_s[QB];
	assign out_item  = item_s[QB];

endmodule

FILE: rtl/scap_sqrt.sv
// ----------------------------------------------------------------------------
// scap_sqrt
// Pipelined integer square root, one result bit per stage.
// ----------------------------------------------------------------------------
module scap_sqrt import scap_pkg::*; (
	input  logic              clk,
	input  logic              en,
	input  logic [SUM_W-1:0]  radicand,
	output logic [ROOT_W-1:0] root
);

	logic [ROOT_W:0]   rem_s  [1:QB];
	logic [ROOT_W-1:0] root_s [1:QB];
	logic [SUM_W-1:0]  x_s    [1:QB];

	// restoring digit step on two radicand bits
	for (genvar g = 1; g <= QB; g++) begin : g_stage
		logic [ROOT_W:0]   r_prev;
		logic [ROOT_W-1:0] q_prev;
		logic [SUM_W-1:0]  x_prev;
		logic [ROOT_W+2:0] trial_v;
		logic [ROOT_W+2:0] part_v;
		logic              ge;
		if (g == 1) begin : g_first
			assign r_prev = '0;
			assign q_prev = '0;
			assign x_prev = radicand;
		end else begin : g_next
			assign r_prev = rem_s[g-1];
			assign q_prev = root_s[g-1];
			assign x_prev = x_s[g-1];
		end
		assign part_v  = {r_prev, x_prev[SUM_W-1 -: 2]};
		assign trial_v = {1'b0, q_prev, 2'b01};
		assign ge      = part_v >= trial_v;
		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[g]  <= ge ? (ROOT_W+1)'(part_v - trial_v) : part_v[ROOT_W:0];
				root_s[g] <= {q_prev[ROOT_W-2:0], ge};
				x_s[g]    <= {x_prev[SUM_W-3:0], 2'b00};
			end
		end
	end

	assign root = root_s[QB];

endmodule

FILE: rtl/scap_div.sv
// ----------------------------------------------------------------------------
// scap_div
// Pipelined restoring divider, one quotient bit per stage. The dividend's
// upper half must be below the divisor.
// ----------------------------------------------------------------------------
module scap_div import scap_pkg::*; (
	input  logic             clk,
	input  logic             en,
	input  logic [NUM_W-1:0] num,
	input  logic [QB-1:0]    den,
	output logic [QB-1:0]    quo
);

	logic [QB-1:0] rem_s [1:QB];
	logic [QB-1:0] low_s [1:QB];
	logic [QB-1:0] den_s [1:QB];
	logic [QB-1:0] quo_s [1:QB];

	// shift in one dividend bit, subtract when it fits
	for (genvar g = 1; g <= QB; g++) begin : g_stage
		logic [QB-1:0] r_prev;
		logic [QB-1:0] l_prev;
		logic [QB-1:0] d_prev;
		logic [QB-1:0] q_prev;
		logic [QB:0]   part_v;
		logic          ge;
		if (g == 1) begin : g_first
			assign r_prev = num[NUM_W-1 -: QB];
			assign l_prev = num[QB-1:0];
			assign d_prev = den;
			assign q_prev = '0;
		end else begin : g_next
			assign r_prev = rem_s[g-1];
			assign l_prev = low_s[g-1];
			assign d_prev = den_s[g-1];
			assign q_prev = quo_s[g-1];
		end
		assign part_v = {r_prev, l_prev[QB-1]};
		assign ge     = part_v >= {1'b0, d_prev};
		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[g] <= ge ? QB'(part_v - {1'b0, d_prev}) : part_v[QB-1:0];
				low_s[g] <= {l_prev[QB-2:0], 1'b0};
				den_s[g] <= d_prev;
				quo_s[g] <= {q_prev[QB-2:0], ge};
			end
		end
	end

	assign quo = quo_s[QB];

endmodule

FILE: rtl/sphere_contact_admm_projection.sv
// ----------------------------------------------------------------------------
// sphere_contact_admm_projection
// Projects one sphere contact constraint per transaction: stiffness update,
// projected point, weighted contribution and weight.
// ----------------------------------------------------------------------------
// Usage
//   Input channel in_valid/in_ready carries target, gap, penalty_weight and
//   stiffness_in; output channel out_valid/out_ready returns the result.
//   Sphere center, radius and margin are written through cfg_we/cfg_index/
//   cfg_data while no transaction is in flight.
//   One item is taken every cycle while in_ready is high; the depth is set
//   by the square root and the three chained 34-stage dividers (stiffness,
//   alpha, projection).
//   All stages advance together: when out_valid is high and out_ready low
//   the whole pipeline holds and in_ready drops, nothing lost or repeated.
//   Reset clears all valid bits and loads the default registers (center 0,
//   radius 1.0, margin 655); the block accepts items as soon as reset is
//   released.
// ----------------------------------------------------------------------------
module sphere_contact_admm_projection import scap_pkg::*; (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [CFG_IDX_W-1:0]        cfg_index,
	input  logic [WORD_BITS-1:0]        cfg_data,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic signed [WORD_BITS-1:0] target_x,
	input  logic signed [WORD_BITS-1:0] target_y,
	input  logic signed [WORD_BITS-1:0] target_z,
	input  logic signed [WORD_BITS-1:0] gap_x,
	input  logic signed [WORD_BITS-1:0] gap_y,
	input  logic signed [WORD_BITS-1:0] gap_z,
	input  logic [UW-1:0]               penalty_weight,
	input  logic [UW-1:0]               stiffness_in,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic signed [WORD_BITS-1:0] proj_x,
	output logic signed [WORD_BITS-1:0] proj_y,
	output logic signed [WORD_BITS-1:0] proj_z,
	output logic [UW-1:0]               stiffness_out,
	output logic signed [WORD_BITS-1:0] contrib_x,
	output logic signed [WORD_BITS-1:0] contrib_y,
	output logic signed [WORD_BITS-1:0] contrib_z,
	output logic [UW-1:0]               weight_out
);

	localparam int APE_W = UW + 1;

	logic [2:0][WORD_BITS-1:0] center_q;
	logic [UW-1:0]             radius_q;
	logic [UW-1:0]             margin_q;
	logic [APE_W-1:0]          ape;
	logic                      en;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_q <= '0;
			radius_q <= UW'(65536);
			margin_q <= UW'(655);
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_CENTER_X: center_q[0] <= cfg_data;
				CFG_CENTER_Y: center_q[1] <= cfg_data;
				CFG_CENTER_Z: center_q[2] <= cfg_data;
				CFG_RADIUS:   radius_q    <= cfg_data[UW-1:0];
				CFG_MARGIN:   margin_q    <= cfg_data[UW-1:0];
				default:      ;
			endcase
		end
	end

	assign ape      = {1'b0, radius_q} + {1'b0, margin_q};
	assign en       = !out_valid || out_ready;
	assign in_ready = en;

	// stage 1: difference vector and magnitudes
	logic [2:0][WORD_BITS-1:0] tgt_v, gap_v;
	item_t item_s1, item_d1;
	logic  valid_s1;

	assign tgt_v = {target_z, target_y, target_x};
	assign gap_v = {gap_z, gap_y, gap_x};

	always_comb begin
		logic signed [DIFF_W-1:0] d;
		item_d1     = '0;
		item_d1.rho = penalty_weight;
		item_d1.k   = stiffness_in;
		for (int i = 0; i < 3; i++) begin
			d = DIFF_W'($signed(tgt_v[i])) - DIFF_W'($signed(gap_v[i]))
				- DIFF_W'($signed(center_q[i]));
			item_d1.u[i]   = gap_v[i];
			item_d1.neg[i] = d[DIFF_W-1];
			item_d1.ad[i]  = d[DIFF_W-1] ? MAG_W'(-d) : MAG_W'(d);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (en)
			valid_s1 <= in_valid;
	end
	always_ff @(posedge clk) begin
		if (en)
			item_s1 <= item_d1;
	end

	// stage 2: squares
	logic [2:0][SQ_W-1:0] sq_s2;
	item_t item_s2;
	logic  valid_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s2 <= 1'b0;
		else if (en)
			valid_s2 <= valid_s1;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			item_s2 <= item_s1;
			for (int i = 0; i < 3; i++)
				sq_s2[i] <= item_s1.ad[i] * item_s1.ad[i];
		end
	end

	// stage 3: sum of squares
	logic [SUM_W-1:0] sum_s3;
	item_t item_s3;
	logic  valid_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s3 <= 1'b0;
		else if (en)
			valid_s3 <= valid_s2;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			item_s3 <= item_s2;
			sum_s3  <= SUM_W'(sq_s2[0]) + SUM_W'(sq_s2[1]) + SUM_W'(sq_s2[2]);
		end
	end

	// distance
	logic [ROOT_W-1:0] root;
	item_t item_sq;
	logic  valid_sq;

	scap_sqrt u_sqrt (.clk(clk), .en(en), .radicand(sum_s3), .root(root));
	scap_delay u_dly_sq (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_valid(valid_s3), .in_item(item_s3),
		.out_valid(valid_sq), .out_item(item_sq)
	);

	// stage 4: excess over radius and stiffness test products
	logic [2*UW-1:0]       pke_s4;
	logic [UW+ROOT_W-1:0]  pre_s4;
	item_t item_s4;
	logic  valid_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s4 <= 1'b0;
		else if (en)
			valid_s4 <= valid_sq;
	end
	always_ff @(posedge clk) begin
		logic              gt;
		logic [ROOT_W-1:0] ex;
		item_t             nxt;
		gt     = root > ROOT_W'(radius_q);
		ex     = gt ? root - ROOT_W'(radius_q) : '0;
		nxt    = item_sq;
		nxt.n  = root;
		nxt.gt = gt;
		if (en) begin
			item_s4      <= nxt;
			pke_s4       <= item_sq.k * margin_q;
			pre_s4       <= item_sq.rho * ex;
		end
	end

	// stage 5: stiffness test and overflow screen
	logic [NUM_W-1:0] knum_s5;
	item_t item_s5;
	logic  valid_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s5 <= 1'b0;
		else if (en)
			valid_s5 <= valid_s4;
	end
	always_ff @(posedge clk) begin
		logic                           fire;
		logic                           ovf;
		logic [UW+ROOT_W+GAIN_SH-1:0]   num4;
		item_t                          nxt;
		fire = item_s4.gt && ((UW+ROOT_W)'(pke_s4) < pre_s4);
		num4 = {pre_s4, GAIN_SH'(0)};
		ovf  = fire && ((margin_q == '0)
			|| (num4[UW+ROOT_W+GAIN_SH-1:UW] >= (ROOT_W+GAIN_SH)'(margin_q)));
		nxt      = item_s4;
		nxt.fire = fire;
		nxt.ovf  = ovf;
		if (en) begin
			item_s5      <= nxt;
			knum_s5      <= (fire && !ovf) ? NUM_W'(num4) : '0;
		end
	end

	// raised stiffness division
	logic [QB-1:0] kq;
	item_t item_kd;
	logic  valid_kd;

	scap_div u_div_k (
		.clk(clk), .en(en), .num(knum_s5), .den(QB'(margin_q)), .quo(kq)
	);
	scap_delay u_dly_k (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_valid(valid_s5), .in_item(item_s5),
		.out_valid(valid_kd), .out_item(item_kd)
	);

	// stage 6: final stiffness and alpha numerator products
	logic [UW+APE_W-1:0]  pk_s6;
	logic [UW+ROOT_W-1:0] pn_s6;
	item_t item_s6;
	logic  valid_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s6 <= 1'b0;
		else if (en)
			valid_s6 <= valid_kd;
	end
	always_ff @(posedge clk) begin
		logic [UW-1:0] knew;
		item_t         nxt;
		knew  = item_kd.fire ? (item_kd.ovf ? UMAX : kq[UW-1:0]) : item_kd.k;
		nxt   = item_kd;
		nxt.k = knew;
		if (en) begin
			item_s6   <= nxt;
			pk_s6     <= knew * ape;
			pn_s6     <= item_kd.rho * item_kd.n;
		end
	end

	// stage 7: alpha numerator and denominator
	logic [NUM_W-1:0] anum_s7;
	logic [QB-1:0]    aden_s7;
	item_t item_s7;
	logic  valid_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s7 <= 1'b0;
		else if (en)
			valid_s7 <= valid_s6;
	end
	always_ff @(posedge clk) begin
		logic [UW:0] kr;
		item_t       nxt;
		kr       = {1'b0, item_s6.k} + {1'b0, item_s6.rho};
		nxt      = item_s6;
		nxt.zero = kr == '0;
		if (en) begin
			item_s7      <= nxt;
			anum_s7      <= NUM_W'(pk_s6) + NUM_W'(pn_s6);
			aden_s7      <= QB'(kr);
		end
	end

	// alpha division
	logic [QB-1:0] aq;
	item_t item_ad;
	logic  valid_ad;

	scap_div u_div_a (.clk(clk), .en(en), .num(anum_s7), .den(aden_s7), .quo(aq));
	scap_delay u_dly_a (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_valid(valid_s7), .in_item(item_s7),
		.out_valid(valid_ad), .out_item(item_ad)
	);

	// stage 8: alpha and offset numerators
	logic [2:0][NUM_W-1:0] pnum_s8;
	item_t item_s8;
	logic  valid_s8;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s8 <= 1'b0;
		else if (en)
			valid_s8 <= valid_ad;
	end
	always_ff @(posedge clk) begin
		logic [QB-1:0] alpha;
		item_t         nxt;
		alpha     = item_ad.zero ? QB'(ape) : aq;
		nxt       = item_ad;
		nxt.alpha = alpha;
		if (en) begin
			item_s8       <= nxt;
			for (int i = 0; i < 3; i++)
				pnum_s8[i] <= NUM_W'(alpha * item_ad.ad[i]);
		end
	end

	// projection offset divisions, one per coordinate
	logic [2:0][QB-1:0] pq;
	item_t item_pd;
	logic  valid_pd;

	for (genvar c = 0; c < 3; c++) begin : g_pdiv
		scap_div u_div_p (
			.clk(clk), .en(en), .num(pnum_s8[c]), .den(item_s8.n), .quo(pq[c])
		);
	end
	scap_delay u_dly_p (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_valid(valid_s8), .in_item(item_s8),
		.out_valid(valid_pd), .out_item(item_pd)
	);

	// stage 9: projected point with saturation
	localparam int PS_W = QB + 2;
	localparam logic signed [PS_W-1:0] SMAX_W = PS_W'({1'b0, UMAX});
	localparam logic signed [PS_W-1:0] SMIN_W = -SMAX_W - PS_W'(1);
	logic [2:0][WORD_BITS-1:0] p_s9;
	item_t item_s9;
	logic  valid_s9;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s9 <= 1'b0;
		else if (en)
			valid_s9 <= valid_pd;
	end
	always_ff @(posedge clk) begin
		logic signed [PS_W-1:0] off;
		logic signed [PS_W-1:0] sum;
		if (en) begin
			item_s9 <= item_pd;
			for (int i = 0; i < 3; i++) begin
				off = item_pd.neg[i] ? -PS_W'(pq[i]) : PS_W'(pq[i]);
				sum = PS_W'($signed(center_q[i])) + off;
				if (item_pd.n == '0)
					p_s9[i] <= center_q[i];
				else if (sum > SMAX_W)
					p_s9[i] <= WORD_BITS'(SMAX_W);
				else if (sum < SMIN_W)
					p_s9[i] <= WORD_BITS'(SMIN_W);
				else
					p_s9[i] <= WORD_BITS'(sum);
			end
		end
	end

	// stage 10: weighted contribution magnitude
	logic [2:0][PRD_W-1:0]     cprod_s10;
	logic [2:0]                cneg_s10;
	logic [2:0][WORD_BITS-1:0] p_s10;
	item_t item_s10;
	logic  valid_s10;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s10 <= 1'b0;
		else if (en)
			valid_s10 <= valid_s9;
	end
	always_ff @(posedge clk) begin
		logic signed [MAG_W-1:0] s;
		logic [MAG_W-1:0]        m;
		if (en) begin
			item_s10 <= item_s9;
			p_s10    <= p_s9;
			for (int i = 0; i < 3; i++) begin
				s = MAG_W'($signed(item_s9.u[i])) + MAG_W'($signed(p_s9[i]));
				m = s[MAG_W-1] ? MAG_W'(-s) : MAG_W'(s);
				cneg_s10[i]  <= s[MAG_W-1];
				cprod_s10[i] <= item_s9.rho * m;
			end
		end
	end

	// stage 11: output register with saturated contribution
	logic [2:0][WORD_BITS-1:0] proj_q, contrib_q;
	logic [UW-1:0]             stiff_q, weight_q;
	logic                      out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (en)
			out_valid_q <= valid_s10;
	end
	always_ff @(posedge clk) begin
		logic [SH_W-1:0]      sh;
		logic [WORD_BITS-1:0] mag;
		if (en) begin
			proj_q   <= p_s10;
			stiff_q  <= item_s10.k;
			weight_q <= item_s10.rho;
			for (int i = 0; i < 3; i++) begin
				sh = cprod_s10[i][PRD_W-1:FRAC_BITS];
				if (cneg_s10[i]) begin
					mag = (sh > SH_W'({1'b1, UW'(0)})) ? {1'b1, UW'(0)} : WORD_BITS'(sh);
					contrib_q[i] <= -mag;
				end else begin
					contrib_q[i] <= (sh > SH_W'(UMAX)) ? {1'b0, UMAX} : WORD_BITS'(sh);
				end
			end
		end
	end

	assign out_valid     = out_valid_q;
	assign proj_x        = proj_q[0];
	assign proj_y        = proj_q[1];
	assign proj_z        = proj_q[2];
	assign stiffness_out = stiff_q;
	assign contrib_x     = contrib_q[0];
	assign contrib_y     = contrib_q[1];
	assign contrib_z     = contrib_q[2];
	assign weight_out    = weight_q;

endmodule
